// ===== src/ppmp_pkg.sv =====
package ppmp_pkg;

	// Result kinds carried on the output side.
	localparam logic [1:0] KIND_PIXEL  = 2'd0;
	localparam logic [1:0] KIND_HEADER = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// Format error codes.
	localparam logic [2:0] ERR_MAGIC    = 3'd0;
	localparam logic [2:0] ERR_NONDIGIT = 3'd1;
	localparam logic [2:0] ERR_EOF      = 3'd2;
	localparam logic [2:0] ERR_TOO_LONG = 3'd3;
	localparam logic [2:0] ERR_SIDE     = 3'd4;

	// Character codes used by the lexer.
	localparam logic [7:0] CH_P       = 8'h50;
	localparam logic [7:0] CH_3       = 8'h33;
	localparam logic [7:0] CH_0       = 8'h30;
	localparam logic [7:0] CH_9       = 8'h39;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_EOF     = 8'hFF;

	// Width of the decimal accumulator: nine digits fit in thirty bits.
	localparam int ACC_W = 30;

	// Depth of the token queue between lexer and field sequencer.
	localparam int QUEUE_DEPTH = 2;

	// One token from the lexer: either a finished number or an error.
	typedef struct packed {
		logic        is_err;
		logic [2:0]  code;
		logic [15:0] value;
	} tok_t;

	// One result word as the sequencer delivers it.
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [11:0] column;
		logic [11:0] row;
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic [15:0] max_value;
		logic        last;
		logic [2:0]  error_code;
	} res_t;

endpackage

// ===== src/ppmp_front.sv =====
module ppmp_front import ppmp_pkg::*; #(
	parameter int NUMBER_LIMIT = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] data_b,
	input  logic       eof_flag,
	input  logic       queue_full,
	output logic       push,
	output tok_t       tok
);

	localparam int CNT_W = $clog2(NUMBER_LIMIT + 1);

	typedef enum logic [2:0] {
		ST_MAGIC_P,
		ST_MAGIC_3,
		ST_SKIP_LINE,
		ST_BETWEEN,
		ST_COMMENT,
		ST_NUMBER,
		ST_DONE
	} state_t;

	state_t             state_q, state_d;
	logic [ACC_W-1:0]   acc_q, acc_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;

	logic               accept;
	logic               eof;
	logic               digit;
	logic               space;
	logic [3:0]         dval;
	logic [CNT_W-1:0]   cnt_inc;
	logic [ACC_W-1:0]   acc_next;
	logic [15:0]        acc_sat;

	assign accept   = in_valid && !queue_full;
	assign eof      = eof_flag || (data_b == CH_EOF);
	assign digit    = !eof && (data_b >= CH_0) && (data_b <= CH_9);
	assign space    = (data_b == CH_SPACE) || ((data_b >= CH_TAB) && (data_b <= CH_CR));
	assign dval     = 4'(data_b - CH_0);
	assign cnt_inc  = cnt_q + CNT_W'(1);
	assign acc_next = ACC_W'((acc_q << 3) + (acc_q << 1) + {{(ACC_W-4){1'b0}}, dval});
	assign acc_sat  = (acc_q > ACC_W'(65535)) ? 16'hFFFF : acc_q[15:0];

	always_comb begin
		state_d = state_q;
		acc_d   = acc_q;
		cnt_d   = cnt_q;
		push    = 1'b0;
		tok     = '0;
		if (accept) begin
			case (state_q)
				ST_MAGIC_P: begin
					if (eof || data_b != CH_P) begin
						push       = 1'b1;
						tok.is_err = 1'b1;
						tok.code   = ERR_MAGIC;
						state_d    = ST_DONE;
					end else begin
						state_d = ST_MAGIC_3;
					end
				end
				ST_MAGIC_3: begin
					if (eof || data_b != CH_3) begin
						push       = 1'b1;
						tok.is_err = 1'b1;
						tok.code   = ERR_MAGIC;
						state_d    = ST_DONE;
					end else begin
						state_d = ST_SKIP_LINE;
					end
				end
				ST_SKIP_LINE, ST_COMMENT: begin
					if (eof) begin
						push       = 1'b1;
						tok.is_err = 1'b1;
						tok.code   = ERR_EOF;
						state_d    = ST_DONE;
					end else if (data_b == CH_LF) begin
						state_d = ST_BETWEEN;
					end
				end
				ST_BETWEEN: begin
					if (eof) begin
						push       = 1'b1;
						tok.is_err = 1'b1;
						tok.code   = ERR_EOF;
						state_d    = ST_DONE;
					end else if (data_b == CH_HASH) begin
						state_d = ST_COMMENT;
					end else if (space) begin
						state_d = ST_BETWEEN;
					end else if (!digit) begin
						push       = 1'b1;
						tok.is_err = 1'b1;
						tok.code   = ERR_NONDIGIT;
						state_d    = ST_DONE;
					end else begin
						acc_d   = {{(ACC_W-4){1'b0}}, dval};
						cnt_d   = CNT_W'(1);
						state_d = ST_NUMBER;
					end
				end
				ST_NUMBER: begin
					if (digit) begin
						if (cnt_inc >= CNT_W'(NUMBER_LIMIT)) begin
							push       = 1'b1;
							tok.is_err = 1'b1;
							tok.code   = ERR_TOO_LONG;
							state_d    = ST_DONE;
						end else begin
							acc_d = acc_next;
							cnt_d = cnt_inc;
						end
					end else begin
						// Any non-digit, end of file included, closes the number.
						push      = 1'b1;
						tok.value = acc_sat;
						acc_d     = '0;
						cnt_d     = '0;
						state_d   = ST_BETWEEN;
					end
				end
				default: begin
					state_d = ST_DONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_MAGIC_P;
			acc_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// ===== src/ppmp_fifo.sv =====
module ppmp_fifo import ppmp_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tok_t push_data,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output tok_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tok_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== src/ppmp_back.sv =====
module ppmp_back import ppmp_pkg::*; #(
	parameter int MAX_SIDE = 4096
) (
	input  logic clk,
	input  logic arst_n,
	input  logic tok_valid,
	input  tok_t tok,
	output logic pop,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	typedef enum logic [2:0] {
		FLD_WIDTH,
		FLD_HEIGHT,
		FLD_MAXVAL,
		FLD_RED,
		FLD_GREEN,
		FLD_BLUE
	} field_t;

	field_t      field_q;
	logic [12:0] width_q;
	logic [12:0] height_q;
	logic [15:0] red_q;
	logic [15:0] green_q;
	logic [11:0] col_q;
	logic [11:0] row_q;
	logic        done_q;
	logic        valid_q;
	res_t        res_q;

	logic        slot_free;
	logic        side_big;
	logic [12:0] col_inc;
	logic [12:0] row_inc;
	logic        col_end;
	logic        row_end;
	logic        take;
	logic        empty_img;
	logic        emit;
	logic        finish;
	res_t        res_d;

	assign slot_free = !valid_q || out_ready;
	// Once finished, tokens are drained and dropped without waiting on the output.
	assign pop       = tok_valid && (done_q || slot_free);
	assign take      = pop && !done_q;
	assign side_big  = tok.value > 16'(MAX_SIDE);
	assign col_inc   = {1'b0, col_q} + 13'd1;
	assign row_inc   = {1'b0, row_q} + 13'd1;
	assign col_end   = col_inc >= width_q;
	assign row_end   = row_inc >= height_q;
	assign empty_img = (width_q == '0) || (height_q == '0);

	assign out_valid = valid_q;
	assign out_res   = res_q;

	// The result word that the token taken this cycle produces, if any.
	always_comb begin
		emit   = 1'b0;
		finish = 1'b0;
		res_d  = '0;
		if (take) begin
			if (tok.is_err) begin
				emit             = 1'b1;
				finish           = 1'b1;
				res_d.kind       = KIND_ERROR;
				res_d.error_code = tok.code;
			end else begin
				case (field_q)
					FLD_WIDTH, FLD_HEIGHT: begin
						if (side_big) begin
							emit             = 1'b1;
							finish           = 1'b1;
							res_d.kind       = KIND_ERROR;
							res_d.error_code = ERR_SIDE;
						end
					end
					FLD_MAXVAL: begin
						emit               = 1'b1;
						finish             = empty_img;
						res_d.kind         = KIND_HEADER;
						res_d.image_width  = width_q;
						res_d.image_height = height_q;
						res_d.max_value    = tok.value;
						res_d.last         = empty_img;
					end
					FLD_RED, FLD_GREEN: begin
					end
					default: begin
						emit         = 1'b1;
						finish       = col_end && row_end;
						res_d.kind   = KIND_PIXEL;
						res_d.red    = red_q;
						res_d.green  = green_q;
						res_d.blue   = tok.value;
						res_d.column = col_q;
						res_d.row    = row_q;
						res_d.last   = col_end && row_end;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q  <= FLD_WIDTH;
			width_q  <= '0;
			height_q <= '0;
			red_q    <= '0;
			green_q  <= '0;
			col_q    <= '0;
			row_q    <= '0;
			done_q   <= 1'b0;
			valid_q  <= 1'b0;
			res_q    <= '0;
		end else begin
			valid_q <= emit || (valid_q && !out_ready);
			if (emit) begin
				res_q <= res_d;
			end
			if (finish) begin
				done_q <= 1'b1;
			end
			if (take && !tok.is_err) begin
				case (field_q)
					FLD_WIDTH: begin
						if (!side_big) begin
							width_q <= tok.value[12:0];
							field_q <= FLD_HEIGHT;
						end
					end
					FLD_HEIGHT: begin
						if (!side_big) begin
							height_q <= tok.value[12:0];
							field_q  <= FLD_MAXVAL;
						end
					end
					FLD_MAXVAL: begin
						field_q <= FLD_RED;
					end
					FLD_RED: begin
						red_q   <= tok.value;
						field_q <= FLD_GREEN;
					end
					FLD_GREEN: begin
						green_q <= tok.value;
						field_q <= FLD_BLUE;
					end
					default: begin
						if (col_end) begin
							col_q <= '0;
							row_q <= row_inc[11:0];
						end else begin
							col_q <= col_inc[11:0];
						end
						field_q <= FLD_RED;
					end
				endcase
			end
		end
	end

endmodule

// ===== src/plain_ppm_stream_parser.sv =====
// A byte's token passes through the token queue before its result word is registered.
// Throughput: one byte per cycle sustained, with a result word delivered per cycle at most.
// The byte side stalls only when the two-entry token queue is full behind a stalled output.
// Reset (arst_n low, asynchronous) returns the parser to expecting the magic string and
// empties the queue and the output register; after an error, the last pixel or the header
// of an empty image, bytes are accepted and dropped until the next reset.
module plain_ppm_stream_parser import ppmp_pkg::*; #(
	parameter int NUMBER_LIMIT = 10,
	parameter int MAX_SIDE     = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // data_byte [7:0]
	input  logic         s_tuser,   // end_of_input [0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [119:0] m_tdata,   // red, green, blue, column, row, image_width,
	                                // image_height, max_value, error_code, zero fill
	output logic [1:0]   m_tuser,   // kind [1:0]
	output logic         m_tlast    // last
);

	// The lexer turns the byte stream into tokens: a finished number, already
	// clamped to sixteen bits, or a format error found in the text itself.
	// The field sequencer after the queue assigns those numbers to header
	// fields and pixel samples, checks the sides and keeps the raster position.
	// Because the sequencer drops every token once it has finished, the lexer
	// need not know when the image has ended.

	logic queue_full;
	logic push;
	tok_t push_tok;
	logic tok_valid;
	tok_t tok;
	logic pop;
	res_t res;

	ppmp_front #(
		.NUMBER_LIMIT(NUMBER_LIMIT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.data_b    (s_tdata),
		.eof_flag  (s_tuser),
		.queue_full(queue_full),
		.push      (push),
		.tok       (push_tok)
	);

	// A word is taken whenever the queue has room, so each byte is accepted in
	// the same cycle that its token, if any, is written.
	assign s_tready = !queue_full;

	ppmp_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_tok),
		.full     (queue_full),
		.pop      (pop),
		.not_empty(tok_valid),
		.pop_data (tok)
	);

	ppmp_back #(
		.MAX_SIDE(MAX_SIDE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.tok_valid(tok_valid),
		.tok      (tok),
		.pop      (pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (res)
	);

	// Output packing, lowest field first, padded with zeros to fifteen bytes.
	assign m_tdata = {3'b000, res.error_code, res.max_value, res.image_height,
		res.image_width, res.row, res.column, res.blue, res.green, res.red};
	assign m_tuser = res.kind;
	assign m_tlast = res.last;

endmodule

// ===== test/tb_plain_ppm_stream_parser.sv =====
`timescale 1ns / 1ps

module tb_plain_ppm_stream_parser;
	import ppmp_pkg::*;

	// The parser runs with its default limits; the checker keeps its own copies.
	localparam int DIGIT_LIMIT = 10;
	localparam int SIDE_LIMIT  = 4096;

	// The opening header declares a 9 x 7 image, so a clean file carries
	// 63 pixels, that is 189 sample numbers after the header.
	localparam int IMG_W         = 9;
	localparam int IMG_H         = 7;
	localparam int PIXEL_NUMBERS = 3 * IMG_W * IMG_H;

	// The sender's pauses and the receiver's stalls are both bounded and far
	// shorter than this limit, so a stretch that long without any word moving on
	// either side can only mean that the parser has hung.
	localparam int STALL_LIMIT  = 1000;
	// The drain allows for a result on its way through the queue and output
	// register, and for a stalled receiver, before we decide nothing more comes.
	localparam int DRAIN_CYCLES = 20;

	// Whole-state names for the checker's own lexer.
	typedef enum logic [2:0] {
		AWAIT_P, AWAIT_3, MAGIC_LINE, GAP, COMMENT, DIGITS, FINISHED
	} lex_phase_t;

	// Which number of the file the next finished number fills.
	typedef enum logic [2:0] {
		F_WIDTH, F_HEIGHT, F_MAXVAL, F_RED, F_GREEN, F_BLUE
	} field_t;

	// How the file is brought to an end; the simulator's seed picks one.
	typedef enum int {
		END_CLEAN, END_EOF_FLAG, END_EOF_BYTE, END_NONDIGIT, END_EARLY_EOF, END_TOO_LONG
	} file_end_t;

	// One byte of the file, with a result word typed in by hand where the row
	// carries one that can be read straight off the text.
	typedef struct packed {
		logic [7:0] txt;
		logic       eof;
		logic       typed;
		res_t       want;
	} byte_row_t;

	localparam res_t NO_WORD = '0;
	// Header of the opening text: 9 x 7, and a maxval of 999999 clamped to 65535.
	localparam res_t HEADER_WORD = {KIND_HEADER, 16'd0, 16'd0, 16'd0, 12'd0, 12'd0,
		13'(IMG_W), 13'(IMG_H), 16'hFFFF, 1'b0, 3'd0};

	// Opening of the file. It walks through the magic line with odd bytes in it
	// (a zero byte and 0xFE), a comment holding a byte with the top bit set,
	// a width with a leading zero ended by CR, a height ended by VT, a comment
	// between header numbers, and a maxval that saturates and is ended by a
	// comma, which is garbage that still closes the number.
	localparam byte_row_t OPENING [25] = '{
		{CH_P,     1'b0, 1'b0, NO_WORD},
		{CH_3,     1'b0, 1'b0, NO_WORD},
		{8'h00,    1'b0, 1'b0, NO_WORD},     // rest of the magic line is skipped
		{8'hFE,    1'b0, 1'b0, NO_WORD},
		{CH_LF,    1'b0, 1'b0, NO_WORD},
		{CH_HASH,  1'b0, 1'b0, NO_WORD},
		{8'h80,    1'b0, 1'b0, NO_WORD},
		{CH_LF,    1'b0, 1'b0, NO_WORD},
		{CH_TAB,   1'b0, 1'b0, NO_WORD},
		{CH_0,     1'b0, 1'b0, NO_WORD},     // width "09"
		{CH_9,     1'b0, 1'b0, NO_WORD},
		{CH_CR,    1'b0, 1'b0, NO_WORD},
		{CH_SPACE, 1'b0, 1'b0, NO_WORD},
		{8'h37,    1'b0, 1'b0, NO_WORD},     // height "7"
		{8'h0B,    1'b0, 1'b0, NO_WORD},
		{CH_HASH,  1'b0, 1'b0, NO_WORD},
		{8'h63,    1'b0, 1'b0, NO_WORD},
		{CH_LF,    1'b0, 1'b0, NO_WORD},
		{CH_9,     1'b0, 1'b0, NO_WORD},     // maxval "999999"
		{CH_9,     1'b0, 1'b0, NO_WORD},
		{CH_9,     1'b0, 1'b0, NO_WORD},
		{CH_9,     1'b0, 1'b0, NO_WORD},
		{CH_9,     1'b0, 1'b0, NO_WORD},
		{CH_9,     1'b0, 1'b0, NO_WORD},
		{8'h2C,    1'b0, 1'b1, HEADER_WORD}
	};

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata  = 8'h00;
	logic         s_tuser  = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [119:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;

	plain_ppm_stream_parser #(
		.NUMBER_LIMIT(DIGIT_LIMIT),
		.MAX_SIDE    (SIDE_LIMIT)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// The whole file, built before the run, and the row now offered on the bus.
	byte_row_t file_rows [$];
	byte_row_t on_bus = '0;
	file_end_t ending;

	// Result words the parser still owes, oldest first.
	res_t pending_words [$];

	int unsigned mismatches     = 0;
	int unsigned bytes_taken    = 0;
	int unsigned pixels_checked = 0;
	int unsigned headers_checked = 0;
	int unsigned errors_checked = 0;
	int unsigned stuck_cycles   = 0;

	// The checker's own copy of the parser state.
	lex_phase_t  lex_phase;
	logic [29:0] acc;
	logic [4:0]  ndigits;
	field_t      field;
	logic [12:0] wid;
	logic [12:0] hgt;
	logic [15:0] maxv;
	logic [15:0] red_hold;
	logic [15:0] green_hold;
	logic [11:0] col;
	logic [11:0] rowc;

	function automatic logic [15:0] clamp16(input int unsigned v);
		return (v > 65535) ? 16'hFFFF : v[15:0];
	endfunction

	// Feeds one byte to the checker's parser; returns 1 when the byte yields a
	// result word, which is then left in r.
	function automatic bit parse_byte(input logic [7:0] b, input logic flag, output res_t r);
		bit          eof;
		bit          digit;
		bit          blank;
		bit          raise;
		bit          made;
		bit          fin;
		logic [2:0]  code;
		int unsigned v;

		r     = '0;
		eof   = flag || (b == CH_EOF);
		digit = !eof && b >= CH_0 && b <= CH_9;
		blank = b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
		raise = 1'b0;
		made  = 1'b0;
		code  = ERR_MAGIC;

		case (lex_phase)
			AWAIT_P: begin
				if (eof || b != CH_P) begin
					raise = 1'b1;
					code  = ERR_MAGIC;
				end else begin
					lex_phase = AWAIT_3;
				end
			end
			AWAIT_3: begin
				if (eof || b != CH_3) begin
					raise = 1'b1;
					code  = ERR_MAGIC;
				end else begin
					lex_phase = MAGIC_LINE;
				end
			end
			MAGIC_LINE, COMMENT: begin
				if (eof) begin
					raise = 1'b1;
					code  = ERR_EOF;
				end else if (b == CH_LF) begin
					lex_phase = GAP;
				end
			end
			GAP: begin
				if (eof) begin
					raise = 1'b1;
					code  = ERR_EOF;
				end else if (b == CH_HASH) begin
					lex_phase = COMMENT;
				end else if (blank) begin
					lex_phase = GAP;
				end else if (!digit) begin
					raise = 1'b1;
					code  = ERR_NONDIGIT;
				end else if (DIGIT_LIMIT <= 1) begin
					raise = 1'b1;
					code  = ERR_TOO_LONG;
				end else begin
					acc       = 30'(b - CH_0);
					ndigits   = 5'd1;
					lex_phase = DIGITS;
				end
			end
			DIGITS: begin
				if (digit) begin
					ndigits = ndigits + 5'd1;
					if (int'(ndigits) >= DIGIT_LIMIT) begin
						raise = 1'b1;
						code  = ERR_TOO_LONG;
					end else begin
						acc = 30'(acc * 10 + (b - CH_0));
					end
				end else begin
					// Any other byte, or the end of the file, closes the number and
					// is itself thrown away, even when it is a hash.
					v         = 32'(acc);
					acc       = '0;
					ndigits   = '0;
					lex_phase = GAP;
					case (field)
						F_WIDTH: begin
							if (v > SIDE_LIMIT) begin
								raise = 1'b1;
								code  = ERR_SIDE;
							end else begin
								wid   = 13'(v);
								field = F_HEIGHT;
							end
						end
						F_HEIGHT: begin
							if (v > SIDE_LIMIT) begin
								raise = 1'b1;
								code  = ERR_SIDE;
							end else begin
								hgt   = 13'(v);
								field = F_MAXVAL;
							end
						end
						F_MAXVAL: begin
							maxv           = clamp16(v);
							field          = F_RED;
							made           = 1'b1;
							r.kind         = KIND_HEADER;
							r.image_width  = wid;
							r.image_height = hgt;
							r.max_value    = maxv;
							if (wid == 0 || hgt == 0) begin
								r.last    = 1'b1;
								lex_phase = FINISHED;
							end
						end
						F_RED: begin
							red_hold = clamp16(v);
							field    = F_GREEN;
						end
						F_GREEN: begin
							green_hold = clamp16(v);
							field      = F_BLUE;
						end
						default: begin
							fin      = (32'(col) + 1 >= 32'(wid)) && (32'(rowc) + 1 >= 32'(hgt));
							made     = 1'b1;
							r.kind   = KIND_PIXEL;
							r.red    = red_hold;
							r.green  = green_hold;
							r.blue   = clamp16(v);
							r.column = col;
							r.row    = rowc;
							r.last   = fin;
							if (32'(col) + 1 >= 32'(wid)) begin
								col  = '0;
								rowc = rowc + 12'd1;
							end else begin
								col = col + 12'd1;
							end
							field = F_RED;
							if (fin)
								lex_phase = FINISHED;
						end
					endcase
				end
			end
			default: begin
				lex_phase = FINISHED;
			end
		endcase

		if (raise) begin
			r            = '0;
			r.kind       = KIND_ERROR;
			r.error_code = code;
			lex_phase    = FINISHED;
			made         = 1'b1;
		end
		return made;
	endfunction

	// Every mismatch goes through here and is printed on a line of its own.
	task automatic note_mismatch(input string msg);
		mismatches++;
		$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input int unsigned got,
	                           input int unsigned want);
		if (got != want)
			note_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	// File building helpers.
	task automatic add_row(input logic [7:0] txt, input logic eof);
		file_rows.push_back({txt, eof, 1'b0, NO_WORD});
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_row(s[i], 1'b0);
	endtask

	task automatic add_digits(input int count);
		repeat (count)
			add_row(CH_0 + 8'($urandom_range(0, 9)), 1'b0);
	endtask

	function automatic logic [7:0] blank_byte();
		case ($urandom_range(0, 5))
			0: return CH_SPACE;
			1: return CH_LF;
			2: return CH_TAB;
			3: return 8'h0B;
			4: return 8'h0C;
			default: return CH_CR;
		endcase
	endfunction

	function automatic logic [7:0] comment_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 254));
		while (b == CH_LF);
		return b;
	endfunction

	// Sample numbers: mostly short, with leading zeros arising by chance, now
	// and then the saturation edge and the longest number the parser takes.
	task automatic add_number();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 3)
			add_text("0");
		else if (pick < 6)
			add_text("65535");
		else if (pick < 9)
			add_text("65536");
		else if (pick < 11)
			add_text("999999999");
		else if (pick < 58)
			add_digits(1);
		else if (pick < 82)
			add_digits($urandom_range(2, 3));
		else if (pick < 94)
			add_digits($urandom_range(4, 6));
		else
			add_digits($urandom_range(7, DIGIT_LIMIT - 1));
	endtask

	// What separates two numbers: a closing byte, usually white space but at
	// times a hash or other garbage, then now and then extra space or a comment.
	task automatic add_gap();
		logic [7:0] b;
		if ($urandom_range(0, 4) != 0) begin
			add_row(blank_byte(), 1'b0);
		end else if ($urandom_range(0, 2) == 0) begin
			add_row(CH_HASH, 1'b0);
		end else begin
			do
				b = 8'($urandom_range(0, 254));
			while (b >= CH_0 && b <= CH_9);
			add_row(b, 1'b0);
		end
		if ($urandom_range(0, 3) == 0) begin
			if ($urandom_range(0, 1) == 0) begin
				add_row(blank_byte(), 1'b0);
			end else begin
				add_row(CH_HASH, 1'b0);
				repeat ($urandom_range(0, 5))
					add_row(comment_byte(), 1'b0);
				add_row(CH_LF, 1'b0);
			end
		end
	endtask

	// The sender offers bytes in bursts of random length, with random pauses
	// between them and now and then a long burst with no pause at all.
	task automatic send_file();
		int unsigned burst_left;
		int unsigned gap;
		burst_left = 0;
		foreach (file_rows[i]) begin
			if (burst_left == 0) begin
				burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
				if (gap != 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
			s_tvalid <= 1'b1;
			s_tdata  <= file_rows[i].txt;
			s_tuser  <= file_rows[i].eof;
			on_bus   <= file_rows[i];
			do
				@(posedge clk);
			while (!s_tready);
		end
		s_tvalid <= 1'b0;
	endtask

	// The receiver follows an eight-bit ready pattern that rotates each cycle
	// and is reloaded at random intervals, a quarter of the time with all ones
	// so that there are stretches without any stall. The pattern is never all
	// zero, so no stall lasts longer than one turn of the pattern.
	logic [7:0] ready_pat    = 8'hFF;
	int unsigned reload_left = 0;

	always @(posedge clk) begin
		if (reload_left == 0) begin
			reload_left <= $urandom_range(20, 80);
			if ($urandom_range(0, 3) == 0)
				ready_pat <= 8'hFF;
			else
				ready_pat <= 8'($urandom) | 8'h01;
		end else begin
			reload_left <= reload_left - 1;
			ready_pat   <= {ready_pat[0], ready_pat[7:1]};
		end
		m_tready <= ready_pat[0];
	end

	// Both sides are sampled at the rising edge, before anything driven at that
	// edge takes effect. A result word is checked against the oldest expected
	// word; an accepted byte is run through the checker's parser, and a row that
	// carries a typed word queues that word instead of the computed one.
	always @(posedge clk) begin : watch_bus
		res_t got;
		res_t want;
		res_t guess;
		bit   made;
		bit   moved;

		if (arst_n) begin
			moved = 1'b0;
			if (m_tvalid && m_tready) begin
				moved = 1'b1;
				if (pending_words.size() == 0) begin
					note_mismatch("result word arrived with nothing expected");
				end else begin
					want             = pending_words.pop_front();
					got.kind         = m_tuser;
					got.red          = m_tdata[15:0];
					got.green        = m_tdata[31:16];
					got.blue         = m_tdata[47:32];
					got.column       = m_tdata[59:48];
					got.row          = m_tdata[71:60];
					got.image_width  = m_tdata[84:72];
					got.image_height = m_tdata[97:85];
					got.max_value    = m_tdata[113:98];
					got.error_code   = m_tdata[116:114];
					got.last         = m_tlast;
					check_field("kind", 32'(got.kind), 32'(want.kind));
					check_field("red", 32'(got.red), 32'(want.red));
					check_field("green", 32'(got.green), 32'(want.green));
					check_field("blue", 32'(got.blue), 32'(want.blue));
					check_field("column", 32'(got.column), 32'(want.column));
					check_field("row", 32'(got.row), 32'(want.row));
					check_field("image_width", 32'(got.image_width),
					            32'(want.image_width));
					check_field("image_height", 32'(got.image_height),
					            32'(want.image_height));
					check_field("max_value", 32'(got.max_value), 32'(want.max_value));
					check_field("error_code", 32'(got.error_code), 32'(want.error_code));
					check_field("last", 32'(got.last), 32'(want.last));
					if (want.kind == KIND_PIXEL)
						pixels_checked++;
					else if (want.kind == KIND_HEADER)
						headers_checked++;
					else
						errors_checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				moved = 1'b1;
				bytes_taken++;
				made = parse_byte(on_bus.txt, on_bus.eof, guess);
				if (on_bus.typed)
					pending_words.push_back(on_bus.want);
				else if (made)
					pending_words.push_back(guess);
			end
			if (moved) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
				if (stuck_cycles >= STALL_LIMIT) begin
					$display("Watchdog: no word moved for %0d cycles.", STALL_LIMIT);
					$display("FAILURE");
					$finish;
				end
			end
		end
	end

	initial begin : run
		int unsigned cut;
		logic [7:0]  b;

		// The checker's parser starts where the block does after reset.
		lex_phase  = AWAIT_P;
		acc        = '0;
		ndigits    = '0;
		field      = F_WIDTH;
		wid        = '0;
		hgt        = '0;
		maxv       = '0;
		red_hold   = '0;
		green_hold = '0;
		col        = '0;
		rowc       = '0;

		// The directed opening first, then the pixel numbers with random content
		// and layout. The seed chooses how the file ends: cleanly after the last
		// pixel with a blank, an end flag or an 0xFF byte closing the last number,
		// or with a fault in the last quarter of the pixels.
		foreach (OPENING[i])
			file_rows.push_back(OPENING[i]);
		ending = file_end_t'($urandom_range(0, 5));
		cut    = $urandom_range(PIXEL_NUMBERS - PIXEL_NUMBERS / 4, PIXEL_NUMBERS - 1);
		for (int n = 0; n < PIXEL_NUMBERS; n++) begin
			if (ending >= END_NONDIGIT && n == cut)
				break;
			add_number();
			if (n != PIXEL_NUMBERS - 1)
				add_gap();
			else if (ending == END_EOF_FLAG)
				add_row(8'($urandom_range(0, 255)), 1'b1);
			else if (ending == END_EOF_BYTE)
				add_row(CH_EOF, 1'b0);
			else
				add_row(blank_byte(), 1'b0);
		end
		if (ending == END_NONDIGIT) begin
			do
				b = 8'($urandom_range(0, 254));
			while ((b >= CH_0 && b <= CH_9) || b == CH_HASH || b == CH_SPACE ||
			       (b >= CH_TAB && b <= CH_CR));
			add_row(b, 1'b0);
		end else if (ending == END_EARLY_EOF) begin
			// The file may stop inside a comment as well as between numbers.
			if ($urandom_range(0, 1) == 0) begin
				add_row(CH_HASH, 1'b0);
				repeat ($urandom_range(0, 4))
					add_row(comment_byte(), 1'b0);
			end
			if ($urandom_range(0, 1) == 0)
				add_row(8'($urandom_range(0, 255)), 1'b1);
			else
				add_row(CH_EOF, 1'b0);
		end else if (ending == END_TOO_LONG) begin
			add_digits(DIGIT_LIMIT);
		end
		// Once the parser has finished, whatever follows must be dropped quietly.
		repeat (16)
			add_row(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_file();

		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Took %0d bytes and checked %0d pixel, %0d header and %0d error words.",
		         bytes_taken, pixels_checked, headers_checked, errors_checked);
		$display("The file was brought to an end by %s.", ending.name());
		if (mismatches == 0 && pending_words.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
